[src/qlrs_pkg.sv]
// ----------------------------------------------------------------------------
// Root solver package
// Shared widths, result codes and the records that travel along the
// root-extraction and divider cell chains.
// ----------------------------------------------------------------------------
package qlrs_pkg;

  // Field widths.
  localparam int unsigned CoefW    = 32;
  localparam int unsigned TolW     = 16;
  localparam int unsigned ProdW    = 64;

  // Root extraction: one result bit per cell.
  localparam int unsigned RootW    = 32;
  localparam int unsigned SqInW    = 64;
  localparam int unsigned SqRemW   = RootW + 3;

  // Division: one quotient bit per cell, three lanes in parallel.
  localparam int unsigned NumLanes = 3;
  localparam int unsigned NumW     = 50;
  localparam int unsigned DivXW    = 51;
  localparam int unsigned DivDW    = CoefW + 1;
  localparam int unsigned DivRW    = CoefW + 2;

  // Signed quotient width after the divider chain.
  localparam int unsigned ResW     = DivXW + 1;

  // Result codes.
  typedef enum logic [2:0] {
    CntNone = 3'd0,
    CntOne  = 3'd1,
    CntTwo  = 3'd2,
    CntInf  = 3'd3,
    CntErr  = 3'd4
  } count_e;

  // Per-item control record carried along both chains.
  typedef struct packed {
    logic                     valid;
    logic                     op;
    logic                     za;
    logic                     zb;
    logic                     dzero;
    logic                     dneg;
    logic [1:0]               dl;
    logic signed [CoefW-1:0]  a;
    logic signed [CoefW-1:0]  b;
    logic [NumLanes-1:0]      neg;
  } tag_t;

  // State handed from one root-extraction cell to the next.
  typedef struct packed {
    tag_t                tag;
    logic [SqRemW-1:0]   rem;
    logic [RootW-1:0]    root;
    logic [SqInW-1:0]    x;
  } sqrt_t;

  // State handed from one divider cell to the next.
  typedef struct packed {
    tag_t                              tag;
    logic [DivDW-1:0]                  den;
    logic [NumLanes-1:0][DivRW-1:0]    rem;
    logic [NumLanes-1:0][DivXW-1:0]    quo;
    logic [NumLanes-1:0][DivXW-1:0]    x;
  } div_t;

  // A 32-bit value counts as zero when it is zero or its magnitude is below tol.
  function automatic logic near_zero32(logic signed [CoefW-1:0] v, logic [TolW-1:0] tol);
    logic [CoefW:0] mag;
    mag = v[CoefW-1] ? (~{1'b1, v} + 1'b1) : {1'b0, v};
    return (v == '0) || (mag < {{(CoefW+1-TolW){1'b0}}, tol});
  endfunction

endpackage

[src/qlrs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Root extraction cell
// Resolves one bit of the integer root per cycle and passes the partial
// remainder, partial root and remaining radicand bits to the next cell.
// ----------------------------------------------------------------------------
module qlrs_sqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qlrs_pkg::sqrt_t   d_i,
  output qlrs_pkg::sqrt_t   q_o
);

  logic                          valid_q;
  qlrs_pkg::sqrt_t               data_q;
  qlrs_pkg::sqrt_t               data_d;
  logic [qlrs_pkg::SqRemW-1:0]   cur;
  logic [qlrs_pkg::SqRemW-1:0]   trial;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    cur    = {d_i.rem[qlrs_pkg::SqRemW-3:0], d_i.x[qlrs_pkg::SqInW-1 -: 2]};
    trial  = {1'b0, d_i.root, 2'b01};
    data_d = d_i;
    data_d.x = {d_i.x[qlrs_pkg::SqInW-3:0], 2'b00};
    if (cur >= trial) begin
      data_d.rem  = cur - trial;
      data_d.root = {d_i.root[qlrs_pkg::RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = cur;
      data_d.root = {d_i.root[qlrs_pkg::RootW-2:0], 1'b0};
    end
  end

  // Valid flag is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    q_o           = data_q;
    q_o.tag.valid = valid_q;
  end

endmodule

[src/qlrs_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit per cycle for each of the three lanes, which
// share one divisor, and passes the partial state to the next cell.
// ----------------------------------------------------------------------------
module qlrs_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qlrs_pkg::div_t   d_i,
  output qlrs_pkg::div_t   q_o
);

  logic                         valid_q;
  qlrs_pkg::div_t               data_q;
  qlrs_pkg::div_t               data_d;
  logic [qlrs_pkg::DivRW-1:0]   cur [qlrs_pkg::NumLanes];
  logic [qlrs_pkg::DivRW-1:0]   den_ext;

  // Restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    den_ext = {1'b0, d_i.den};
    data_d  = d_i;
    for (int l = 0; l < qlrs_pkg::NumLanes; l++) begin
      cur[l] = {d_i.rem[l][qlrs_pkg::DivRW-2:0], d_i.x[l][qlrs_pkg::DivXW-1]};
      data_d.x[l] = {d_i.x[l][qlrs_pkg::DivXW-2:0], 1'b0};
      if (cur[l] >= den_ext) begin
        data_d.rem[l] = cur[l] - den_ext;
        data_d.quo[l] = {d_i.quo[l][qlrs_pkg::DivXW-2:0], 1'b1};
      end else begin
        data_d.rem[l] = cur[l];
        data_d.quo[l] = {d_i.quo[l][qlrs_pkg::DivXW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    q_o           = data_q;
    q_o.tag.valid = valid_q;
  end

endmodule

[src/quadratic_linear_root_solver_core.sv]
// Throughput: one item per cycle; busy is never raised.
// Each item passes the 32-cell root extraction chain and the 51-cell divider
// chain, plus nine stages for products, setup and result selection.
// Reset clears all pipeline valid flags and sets the zero tolerance to 1.
// Results appear for one cycle on result_valid_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Quadratic and linear root solver
// Real roots of a*x^2 + b*x + c or a*x + b in signed Q16.16, with rounding,
// saturation and a configurable zero tolerance.
// ----------------------------------------------------------------------------
module quadratic_linear_root_solver_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic signed [qlrs_pkg::CoefW-1:0]   coef_a_i,
  input  logic signed [qlrs_pkg::CoefW-1:0]   coef_b_i,
  input  logic signed [qlrs_pkg::CoefW-1:0]   coef_c_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qlrs_pkg::TolW-1:0]           cfg_data_i,
  output logic                                result_valid_o,
  output logic [2:0]                          root_count_o,
  output logic signed [qlrs_pkg::CoefW-1:0]   root_one_o,
  output logic signed [qlrs_pkg::CoefW-1:0]   root_two_o,
  output logic                                saturated_o
);

  logic                     accept;
  logic [qlrs_pkg::TolW-1:0] tol_q;

  // Handshake: the pipeline takes one item every cycle.
  assign busy        = 1'b0;
  assign accept      = start & ~busy;
  assign cfg_ready_o = 1'b1;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qlrs_pkg::TolW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  // Stage 1: products and near-zero tests on the coefficients.
  logic                                s1_valid_q;
  logic                                s1_op_q, s1_za_q, s1_zb_q;
  logic signed [qlrs_pkg::CoefW-1:0]   s1_a_q, s1_b_q;
  logic signed [qlrs_pkg::ProdW-1:0]   s1_p_q, s1_ac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q <= op_i;
    s1_a_q  <= coef_a_i;
    s1_b_q  <= coef_b_i;
    s1_za_q <= qlrs_pkg::near_zero32(coef_a_i, tol_q);
    s1_zb_q <= qlrs_pkg::near_zero32(coef_b_i, tol_q);
    s1_p_q  <= coef_b_i * coef_b_i;
    s1_ac_q <= coef_a_i * coef_c_i;
  end

  // Stage 2: quarter discriminant dq = floor(b*b/4) - a*c, low bits kept apart.
  logic                                s2_valid_q;
  logic                                s2_op_q, s2_za_q, s2_zb_q;
  logic signed [qlrs_pkg::CoefW-1:0]   s2_a_q, s2_b_q;
  logic signed [qlrs_pkg::ProdW-1:0]   s2_dq_q;
  logic [1:0]                          s2_dl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q <= s1_op_q;
    s2_za_q <= s1_za_q;
    s2_zb_q <= s1_zb_q;
    s2_a_q  <= s1_a_q;
    s2_b_q  <= s1_b_q;
    s2_dq_q <= (s1_p_q >>> 2) - s1_ac_q;
    s2_dl_q <= s1_p_q[1:0];
  end

  // Stage 3: near-zero discriminant test and root chain setup.
  logic              s3_valid_q;
  qlrs_pkg::sqrt_t   s3_data_q, s3_data_d;
  logic              dq_in_range;
  logic signed [42:0] disc_v;
  logic [42:0]       disc_mag;
  logic              dzero;

  always_comb begin
    dq_in_range = (s2_dq_q[63:40] == '0) ||
                  ((s2_dq_q[63:40] == '1) && (s2_dq_q[39:0] != '0));
    disc_v      = {s2_dq_q[40:0], s2_dl_q};
    disc_mag    = disc_v[42] ? (~disc_v + 1'b1) : disc_v;
    dzero       = dq_in_range &&
                  ((disc_v == '0) || (disc_mag < {11'b0, tol_q, 16'b0}));

    s3_data_d           = '0;
    s3_data_d.tag.op    = s2_op_q;
    s3_data_d.tag.za    = s2_za_q;
    s3_data_d.tag.zb    = s2_zb_q;
    s3_data_d.tag.dzero = dzero;
    s3_data_d.tag.dneg  = s2_dq_q[63];
    s3_data_d.tag.dl    = s2_dl_q;
    s3_data_d.tag.a     = s2_a_q;
    s3_data_d.tag.b     = s2_b_q;
    s3_data_d.x         = s2_dq_q[63] ? '0 : s2_dq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_data_q <= s3_data_d;
  end

  // Root extraction chain: floor root of dq, one bit per cell.
  qlrs_pkg::sqrt_t sq [qlrs_pkg::RootW+1];

  always_comb begin
    sq[0]           = s3_data_q;
    sq[0].tag.valid = s3_valid_q;
  end

  for (genvar i = 0; i < qlrs_pkg::RootW; i++) begin : g_sqrt
    qlrs_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .d_i   (sq[i]),
      .q_o   (sq[i+1])
    );
  end

  // Stage 4: root of the full discriminant, s = 2*s0 plus a rounding bit.
  logic                  s4_valid_q;
  qlrs_pkg::tag_t        s4_tag_q;
  logic [qlrs_pkg::RootW+1:0] s4_s_q;
  logic [35:0]           s4_lhs, s4_rhs;

  always_comb begin
    s4_lhs = {2'b0, sq[qlrs_pkg::RootW].root, 2'b01};
    s4_rhs = {sq[qlrs_pkg::RootW].rem[33:0], 2'b00} + {34'b0, sq[qlrs_pkg::RootW].tag.dl};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= sq[qlrs_pkg::RootW].tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_tag_q <= sq[qlrs_pkg::RootW].tag;
    s4_s_q   <= {1'b0, sq[qlrs_pkg::RootW].root, 1'b0} +
                {{(qlrs_pkg::RootW+1){1'b0}}, (s4_lhs <= s4_rhs)};
  end

  // Stage 5: signed numerators for the three lanes.
  logic                  s5_valid_q;
  qlrs_pkg::tag_t        s5_tag_q;
  logic signed [qlrs_pkg::NumW-1:0] s5_num_q [qlrs_pkg::NumLanes];
  logic signed [32:0]    negb;
  logic signed [35:0]    sum_p, sum_m;

  always_comb begin
    negb  = -{s4_tag_q.b[31], s4_tag_q.b};
    sum_p = {{3{negb[32]}}, negb} + {2'b0, s4_s_q};
    sum_m = {{3{negb[32]}}, negb} - {2'b0, s4_s_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_tag_q    <= s4_tag_q;
    // Lane 0 is -b/(2a) for a quadratic and -b/a for a linear item.
    s5_num_q[0] <= s4_tag_q.op ? {negb[32], negb, 16'b0} : {{2{negb[32]}}, negb, 15'b0};
    s5_num_q[1] <= {sum_p[34:0], 15'b0};
    s5_num_q[2] <= {sum_m[34:0], 15'b0};
  end

  // Stage 6: magnitudes and rounding offset, divider chain setup.
  logic             s6_valid_q;
  qlrs_pkg::div_t   s6_data_q, s6_data_d;
  logic [qlrs_pkg::CoefW:0]  ud_ext;
  logic [qlrs_pkg::CoefW-1:0] ud;
  logic [qlrs_pkg::NumW-1:0] un_ext [qlrs_pkg::NumLanes];

  always_comb begin
    ud_ext = s5_tag_q.a[31] ? (~{1'b1, s5_tag_q.a} + 1'b1) : {1'b0, s5_tag_q.a};
    ud     = ud_ext[qlrs_pkg::CoefW-1:0];
    s6_data_d     = '0;
    s6_data_d.tag = s5_tag_q;
    s6_data_d.den = {ud, 1'b0};
    for (int l = 0; l < qlrs_pkg::NumLanes; l++) begin
      un_ext[l] = s5_num_q[l][qlrs_pkg::NumW-1] ? (~s5_num_q[l] + 1'b1) : s5_num_q[l];
      s6_data_d.x[l] = {1'b0, un_ext[l][qlrs_pkg::NumW-2:0], 1'b0} +
                       {{(qlrs_pkg::DivXW-qlrs_pkg::CoefW){1'b0}}, ud};
      s6_data_d.tag.neg[l] = s5_num_q[l][qlrs_pkg::NumW-1] ^ s5_tag_q.a[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_data_q <= s6_data_d;
  end

  // Divider chain: rounded quotient magnitudes, one bit per cell.
  qlrs_pkg::div_t dv [qlrs_pkg::DivXW+1];

  always_comb begin
    dv[0]           = s6_data_q;
    dv[0].tag.valid = s6_valid_q;
  end

  for (genvar i = 0; i < qlrs_pkg::DivXW; i++) begin : g_div
    qlrs_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .d_i   (dv[i]),
      .q_o   (dv[i+1])
    );
  end

  // Stage 7: apply the quotient signs.
  logic              s7_valid_q;
  qlrs_pkg::tag_t    s7_tag_q;
  logic signed [qlrs_pkg::ResW-1:0] s7_r_q [qlrs_pkg::NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else begin
      s7_valid_q <= dv[qlrs_pkg::DivXW].tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_tag_q <= dv[qlrs_pkg::DivXW].tag;
    for (int l = 0; l < qlrs_pkg::NumLanes; l++) begin
      s7_r_q[l] <= dv[qlrs_pkg::DivXW].tag.neg[l] ?
                   -{1'b0, dv[qlrs_pkg::DivXW].quo[l]} : {1'b0, dv[qlrs_pkg::DivXW].quo[l]};
    end
  end

  // Stage 8: root difference and clipping of each lane.
  logic              s8_valid_q;
  qlrs_pkg::tag_t    s8_tag_q;
  logic signed [qlrs_pkg::ResW:0] s8_diff_q;
  logic [qlrs_pkg::CoefW-1:0] s8_clip_q [qlrs_pkg::NumLanes];
  logic [qlrs_pkg::NumLanes-1:0] s8_sat_q;
  logic [qlrs_pkg::ResW-qlrs_pkg::CoefW:0] hi_bits [qlrs_pkg::NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_valid_q <= 1'b0;
    end else begin
      s8_valid_q <= s7_valid_q;
    end
  end

  always_comb begin
    for (int l = 0; l < qlrs_pkg::NumLanes; l++) begin
      hi_bits[l] = s7_r_q[l][qlrs_pkg::ResW-1:qlrs_pkg::CoefW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s8_tag_q  <= s7_tag_q;
    s8_diff_q <= {s7_r_q[1][qlrs_pkg::ResW-1], s7_r_q[1]} -
                 {s7_r_q[2][qlrs_pkg::ResW-1], s7_r_q[2]};
    for (int l = 0; l < qlrs_pkg::NumLanes; l++) begin
      if ((hi_bits[l] == '0) || (hi_bits[l] == '1)) begin
        s8_clip_q[l] <= s7_r_q[l][qlrs_pkg::CoefW-1:0];
        s8_sat_q[l]  <= 1'b0;
      end else begin
        s8_clip_q[l] <= s7_r_q[l][qlrs_pkg::ResW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        s8_sat_q[l]  <= 1'b1;
      end
    end
  end

  // Stage 9: classify the equation and register the result.
  logic [qlrs_pkg::ResW:0] diff_mag;
  logic                  diff_zero;
  qlrs_pkg::count_e      count_d;
  logic [qlrs_pkg::CoefW-1:0] one_d, two_d;
  logic                  sat_d;
  logic                  result_valid_q;
  logic [2:0]            count_q;
  logic [qlrs_pkg::CoefW-1:0] one_q, two_q;
  logic                  sat_q;

  always_comb begin
    diff_mag  = s8_diff_q[qlrs_pkg::ResW] ? (~s8_diff_q + 1'b1) : s8_diff_q;
    diff_zero = (s8_diff_q == '0) ||
                (diff_mag < {{(qlrs_pkg::ResW+1-qlrs_pkg::TolW){1'b0}}, tol_q});
    count_d   = qlrs_pkg::CntNone;
    if (s8_tag_q.op) begin
      if (!s8_tag_q.za) begin
        count_d = qlrs_pkg::CntOne;
      end else if (!s8_tag_q.zb) begin
        count_d = qlrs_pkg::CntNone;
      end else begin
        count_d = qlrs_pkg::CntInf;
      end
    end else if (s8_tag_q.za) begin
      count_d = qlrs_pkg::CntErr;
    end else if (s8_tag_q.dzero) begin
      count_d = qlrs_pkg::CntOne;
    end else if (!s8_tag_q.dneg) begin
      count_d = diff_zero ? qlrs_pkg::CntOne : qlrs_pkg::CntTwo;
    end else begin
      count_d = qlrs_pkg::CntNone;
    end

    case (count_d)
      qlrs_pkg::CntOne: begin
        one_d = s8_clip_q[0];
        two_d = s8_clip_q[0];
        sat_d = s8_sat_q[0];
      end
      qlrs_pkg::CntTwo: begin
        one_d = s8_clip_q[1];
        two_d = s8_clip_q[2];
        sat_d = s8_sat_q[1] | s8_sat_q[2];
      end
      default: begin
        one_d = '0;
        two_d = '0;
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= s8_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    one_q   <= one_d;
    two_q   <= two_d;
    sat_q   <= sat_d;
  end

  assign result_valid_o = result_valid_q;
  assign root_count_o   = count_q;
  assign root_one_o     = one_q;
  assign root_two_o     = two_q;
  assign saturated_o    = sat_q;

`ifndef SYNTH
  // Counts without roots carry zero roots and no saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (root_count_o == qlrs_pkg::CntNone ||
                       root_count_o == qlrs_pkg::CntInf ||
                       root_count_o == qlrs_pkg::CntErr)
    |-> (root_one_o == '0) && (root_two_o == '0) && !saturated_o)
    else $error("root fields not cleared for a rootless result");

  // A single root is reported in both root fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (root_count_o == qlrs_pkg::CntOne) |-> (root_one_o == root_two_o))
    else $error("single root differs between root fields");

  // Saturation implies a root at one of the range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && saturated_o |->
      (root_one_o == 32'h7FFF_FFFF) || (root_one_o == 32'h8000_0000) ||
      (root_two_o == 32'h7FFF_FFFF) || (root_two_o == 32'h8000_0000))
    else $error("saturation flagged without a clipped root");
`endif

endmodule
